// ----- hw/rtl/i2a_pkg.sv -----
// ---------------------------------------------------------------------------
// i2a_pkg
// Shared constants, types and the digit character table for the integer
// to ASCII formatter.
// ---------------------------------------------------------------------------
package i2a_pkg;

    localparam int MAX_WIDTH     = 64;
    localparam int MAX_PRECISION = 48;
    localparam int OUT_CAP       = 64;

    localparam int VALUE_W = 64;
    localparam int FW_W    = 7;
    localparam int PREC_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 7;
    localparam int HEAD_W  = 3 * CHAR_W;

    // digit register: one nibble per digit, sized for octal (the longest)
    localparam int NDIG    = (VALUE_W + 2) / 3;
    localparam int DIG_W   = 4 * NDIG;
    localparam int NDIG_W  = $clog2(NDIG + 1);
    localparam int BCD_DIG = 20;
    localparam int STEP_W  = $clog2(VALUE_W);

    localparam int IN_W  = 88;
    localparam int OUT_W = 8;

    localparam logic [1:0] BASE_OCT     = 2'd0;
    localparam logic [1:0] BASE_DEC     = 2'd1;
    localparam logic [1:0] BASE_HEX     = 2'd2;
    localparam logic [1:0] BASE_HEX_ALT = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [16*CHAR_W-1:0] DIGIT_TABLE = "0123456789ABCDEF";

    // control from the formatter to the digit unit
    typedef struct packed {
        logic               start;
        logic [1:0]         base;
        logic [VALUE_W-1:0] mag;
        logic               shift;
    } dig_ctl_t;

    // status from the digit unit
    typedef struct packed {
        logic              done;
        logic [NDIG_W-1:0] ndig;
    } dig_stat_t;

    typedef enum logic [2:0] {
        DU_IDLE   = 3'b001,
        DU_DABBLE = 3'b010,
        DU_NORM   = 3'b100
    } du_state_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SIZE  = 5'b00100,
        ST_SETUP = 5'b01000,
        ST_EMIT  = 5'b10000
    } fmt_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [3:0] idx;
        idx = 4'd15 - d;
        return DIGIT_TABLE[CHAR_W*idx +: CHAR_W];
    endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer conversion: one 64-bit integer in, its text out one
// ASCII character per item.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item carries the value and its format (base,
//   signedness, sign/prefix/pad flags, field width, precision). s_tready is
//   high while the block is free; one number is formatted at a time.
//   Output channel m_*: one character per item, m_tlast on the final one.
//   Text = [pad][sign][prefix][zero pad][precision zeros][digits][pad].
// Timing:
//   Octal and hex digits load straight from the magnitude; decimal goes
//   through a bit-serial binary-to-BCD shifter. Leading zero digits are
//   then shifted out one per cycle (up to 21). The states ST_SIZE and
//   ST_SETUP size the fields, then one character per cycle while the
//   receiver takes them.
// Reset clears all control; no item is in flight afterwards.
// A stalled receiver holds the output register and pauses the emitter;
// the next number is accepted as soon as the last character is loaded.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // value[63:0], is_signed[64], base_sel[66:65], left_justify[67],
    // plus_sign[68], space_sign[69], alt_prefix[70], zero_pad[71],
    // min_width[78:72], precision[84:79], zero fill[87:85]
    input  logic [i2a_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // text_char[7:0]
    output logic [i2a_pkg::OUT_W-1:0] m_tdata,
    output logic                     m_tlast
);
    import i2a_pkg::*;

    // input field split
    logic [VALUE_W-1:0] in_value;
    logic               in_signed, in_left, in_plus, in_space, in_alt, in_zpad;
    logic [1:0]         in_base;
    logic [FW_W-1:0]    in_fw;
    logic [PREC_W-1:0]  in_prec;

    assign in_value  = s_tdata[63:0];
    assign in_signed = s_tdata[64];
    assign in_base   = s_tdata[66:65];
    assign in_left   = s_tdata[67];
    assign in_plus   = s_tdata[68];
    assign in_space  = s_tdata[69];
    assign in_alt    = s_tdata[70];
    assign in_zpad   = s_tdata[71];
    assign in_fw     = s_tdata[78:72];
    assign in_prec   = s_tdata[84:79];

    fmt_state_t         state_reg, state_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [1:0]         hl_reg, hl_next;
    logic               left_reg, left_next;
    logic               zpad_reg, zpad_next;
    logic [FW_W-1:0]    fw_reg, fw_next;
    logic [PREC_W-1:0]  prec_reg, prec_next;
    logic [POS_W-1:0]   zeros_reg, zeros_next;
    logic [POS_W-1:0]   body_reg, body_next;
    logic [POS_W-1:0]   b1_reg, b1_next;
    logic [POS_W-1:0]   b2_reg, b2_next;
    logic [POS_W-1:0]   b3_reg, b3_next;
    logic [POS_W-1:0]   b4_reg, b4_next;
    logic [POS_W-1:0]   bend_reg, bend_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]  ochar_reg, ochar_next;
    logic               olast_reg, olast_next;

    dig_ctl_t           dctl;
    dig_stat_t          dstat;
    logic [3:0]         top_digit;

    logic               accept;
    logic               neg;
    logic               has_sign;
    logic [CHAR_W-1:0]  sign_ch;
    logic [2*CHAR_W-1:0] pfx;
    logic [1:0]         pfx_len;
    logic [POS_W-1:0]   ndig7;
    logic [POS_W-1:0]   prec7;
    logic [POS_W-1:0]   pad;
    logic               emit_fire;
    logic               in_front, in_head, in_zero, in_dig;
    logic               is_last;
    logic [CHAR_W-1:0]  cur_char;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // sign and radix prefix
    assign neg      = in_signed && in_value[VALUE_W-1];
    assign has_sign = in_signed && (in_value[VALUE_W-1] || in_plus || in_space);
    assign sign_ch  = in_value[VALUE_W-1] ? CH_MINUS : (in_plus ? CH_PLUS : CH_SPACE);

    always_comb
    begin
        pfx     = {CH_NUL, CH_NUL};
        pfx_len = 2'd0;
        case (in_base) inside
            BASE_OCT:
            begin
                if (in_alt)
                begin
                    pfx     = {CH_ZERO, CH_NUL};
                    pfx_len = 2'd1;
                end
            end
            BASE_HEX, BASE_HEX_ALT:
            begin
                if (in_alt)
                begin
                    pfx     = {CH_ZERO, CH_X};
                    pfx_len = 2'd2;
                end
            end
            default:
            begin
                pfx_len = 2'd0;
            end
        endcase
    end

    assign dctl.start = accept;
    assign dctl.base  = in_base;
    assign dctl.mag   = neg ? (VALUE_W'(0) - in_value) : in_value;
    assign dctl.shift = emit_fire && in_dig;

    i2a_digit_unit u_digits
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dctl),
        .stat      (dstat),
        .top_digit (top_digit)
    );

    assign ndig7 = POS_W'(dstat.ndig);
    assign prec7 = POS_W'(prec_reg);
    assign pad   = (POS_W'(fw_reg) > body_reg) ? (POS_W'(fw_reg) - body_reg) : '0;

    // character selection by position against segment boundaries
    assign in_front = (pos_reg < b1_reg);
    assign in_head  = !in_front && (pos_reg < b2_reg);
    assign in_zero  = (pos_reg >= b2_reg) && (pos_reg < b3_reg);
    assign in_dig   = (state_reg == ST_EMIT) && (pos_reg >= b3_reg) && (pos_reg < b4_reg);
    assign is_last  = (pos_reg == bend_reg - 1'b1) || (pos_reg == POS_W'(OUT_CAP - 1));

    always_comb
    begin
        if (in_front)
        begin
            cur_char = CH_SPACE;
        end
        else if (in_head)
        begin
            cur_char = head_reg[HEAD_W-1 -: CHAR_W];
        end
        else if (in_zero)
        begin
            cur_char = CH_ZERO;
        end
        else if (pos_reg < b4_reg)
        begin
            cur_char = digit_char(top_digit);
        end
        else
        begin
            cur_char = CH_SPACE;
        end
    end

    assign emit_fire = (state_reg == ST_EMIT) && (!ovalid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        hl_next     = hl_reg;
        left_next   = left_reg;
        zpad_next   = zpad_reg;
        fw_next     = fw_reg;
        prec_next   = prec_reg;
        zeros_next  = zeros_reg;
        body_next   = body_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        b3_next     = b3_reg;
        b4_next     = b4_reg;
        bend_next   = bend_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    head_next  = has_sign ? {sign_ch, pfx} : {pfx, CH_NUL};
                    hl_next    = {1'b0, has_sign} + pfx_len;
                    left_next  = in_left;
                    zpad_next  = in_zpad;
                    fw_next    = (in_fw > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_fw;
                    prec_next  = (in_prec > PREC_W'(MAX_PRECISION)) ?
                                 PREC_W'(MAX_PRECISION) : in_prec;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (dstat.done)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                zeros_next = (prec7 > ndig7) ? (prec7 - ndig7) : '0;
                body_next  = POS_W'(hl_reg) + zeros_next + ndig7;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                b1_next    = (!left_reg && !zpad_reg) ? pad : '0;
                b2_next    = b1_next + POS_W'(hl_reg);
                b3_next    = b2_next + ((!left_reg && zpad_reg) ? pad : '0) + zeros_reg;
                b4_next    = b3_next + ndig7;
                bend_next  = b4_next + (left_reg ? pad : '0);
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = cur_char;
                    olast_next  = is_last;
                    pos_next    = pos_reg + 1'b1;
                    if (in_head)
                    begin
                        head_next = {head_reg[HEAD_W-CHAR_W-1:0], CH_NUL};
                    end
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        hl_reg    <= hl_next;
        left_reg  <= left_next;
        zpad_reg  <= zpad_next;
        fw_reg    <= fw_next;
        prec_reg  <= prec_next;
        zeros_reg <= zeros_next;
        body_reg  <= body_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        b3_reg    <= b3_next;
        b4_reg    <= b4_next;
        bend_reg  <= bend_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ochar_reg;
    assign m_tlast  = olast_reg;

    // an accepted number starts the digit unit
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CONV))
        else $error("accepted item did not enter conversion");

    // digit unit finishes only while the formatter waits for it
    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |-> (state_reg == ST_CONV))
        else $error("digit unit done outside conversion");

    // emission never runs past the character cap
    a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg < POS_W'(OUT_CAP)))
        else $error("emit position beyond cap");

    // every number produces at least one character
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (bend_reg != '0))
        else $error("empty text");

    // the final character is presented with tlast and the block frees up
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("last character not flagged");

endmodule

// ----- hw/rtl/i2a_digit_unit.sv -----
// ---------------------------------------------------------------------------
// i2a_digit_unit
// Turns a magnitude into a nibble-per-digit shift register, most
// significant digit on top, and counts the significant digits.
// ---------------------------------------------------------------------------
module i2a_digit_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  i2a_pkg::dig_ctl_t ctl,
    output i2a_pkg::dig_stat_t stat,
    output logic [3:0]        top_digit
);
    import i2a_pkg::*;

    du_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [DIG_W-1:0]    dig_reg, dig_next;
    logic [DIG_W-1:0]    adj;
    logic [NDIG_W-1:0]   ndig_reg, ndig_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                done;

    // octal digits are 3-bit groups widened to nibbles
    function automatic logic [DIG_W-1:0] oct_spread(input logic [VALUE_W-1:0] v);
        logic [3*NDIG-1:0] ext;
        logic [DIG_W-1:0]  r;
        ext = {{(3*NDIG-VALUE_W){1'b0}}, v};
        r   = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            r[4*i +: 4] = {1'b0, ext[3*i +: 3]};
        end
        return r;
    endfunction

    // double dabble: add 3 to every BCD digit of 5 or more
    always_comb
    begin
        adj = dig_reg;
        for (int i = 0; i < BCD_DIG; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        dig_next   = dig_reg;
        ndig_next  = ndig_reg;
        step_next  = step_reg;
        done       = 1'b0;
        unique case (state_reg)
            DU_IDLE:
            begin
                if (ctl.start)
                begin
                    mag_next  = ctl.mag;
                    ndig_next = NDIG_W'(NDIG);
                    step_next = '0;
                    case (ctl.base) inside
                        BASE_OCT:
                        begin
                            dig_next   = oct_spread(ctl.mag);
                            state_next = DU_NORM;
                        end
                        BASE_DEC:
                        begin
                            dig_next   = '0;
                            state_next = DU_DABBLE;
                        end
                        default:
                        begin
                            dig_next   = {{(DIG_W-VALUE_W){1'b0}}, ctl.mag};
                            state_next = DU_NORM;
                        end
                    endcase
                end
                else if (ctl.shift)
                begin
                    dig_next = {dig_reg[DIG_W-5:0], 4'd0};
                end
            end
            DU_DABBLE:
            begin
                dig_next  = {adj[DIG_W-2:0], mag_reg[VALUE_W-1]};
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(VALUE_W - 1))
                begin
                    state_next = DU_NORM;
                end
            end
            DU_NORM:
            begin
                // drop leading zero digits, keep at least one
                if (dig_reg[DIG_W-1 -: 4] == 4'd0 && ndig_reg > NDIG_W'(1))
                begin
                    dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = DU_IDLE;
                end
            end
            default:
            begin
                state_next = DU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DU_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
    end

    assign stat.done = done;
    assign stat.ndig = ndig_reg;
    assign top_digit = dig_reg[DIG_W-1 -: 4];

endmodule

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_ascii_formatter. A table of directed
// numbers covers the field extremes, every radix, sign and pad mode; random
// numbers with mixed formats follow. Each accepted number is expanded into
// its expected text by a local formatter, and every character that leaves
// the block is compared in order. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
    import i2a_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  RESET_CYC   = 5;
    localparam int  RANDOM_NUMS = 105;
    localparam int  TAIL_CYC    = 200;
    localparam int  STALL_LIMIT = 3000;

    localparam logic [CHAR_W-1:0] CH_A = 8'h41;

    // flag bits for the directed table: {left, plus, space, alt, zero pad}
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_PLUS  = 5'b01000;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ALT   = 5'b00010;
    localparam logic [4:0] F_ZPAD  = 5'b00001;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_signed;
        logic [1:0]         base_sel;
        logic               left_justify;
        logic               plus_sign;
        logic               space_sign;
        logic               alt_prefix;
        logic               zero_pad;
        logic [FW_W-1:0]    min_width;
        logic [PREC_W-1:0]  precision;
    } num_fmt_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    // directed row: format plus the text when it is obvious, else empty
    typedef struct {
        num_fmt_t fmt;
        string    text;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    text_char_t pending_chars[$];
    dir_row_t   dir_rows[$];
    int         mismatch_count = 0;
    int         idle_cycles    = 0;

    integer_to_ascii_formatter uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic logic [IN_W-1:0] pack_number(input num_fmt_t f);
        return {3'b000, f.precision, f.min_width, f.zero_pad, f.alt_prefix,
                f.space_sign, f.plus_sign, f.left_justify, f.base_sel,
                f.is_signed, f.value};
    endfunction

    function automatic void put_char(ref logic [CHAR_W-1:0] txt[$],
                                     input logic [CHAR_W-1:0] c);
        if (txt.size() < OUT_CAP)
            txt.push_back(c);
    endfunction

    // printf-style expansion of one number into its characters
    function automatic void format_number(input num_fmt_t f,
                                          ref logic [CHAR_W-1:0] txt[$]);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] d;
        logic [CHAR_W-1:0]  head[$];
        logic [CHAR_W-1:0]  digits[$];
        int                 fw;
        int                 prec;
        int                 zeros;
        int                 body;
        int                 pad;

        txt.delete();
        mag  = f.value;
        fw   = (f.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(f.min_width);
        prec = (f.precision > MAX_PRECISION) ? MAX_PRECISION : int'(f.precision);
        case (f.base_sel)
            BASE_OCT: radix = 8;
            BASE_DEC: radix = 10;
            default:  radix = 16;   // hex and the spare code
        endcase

        // sign only for signed input; the most negative value wraps to 2^63
        if (f.is_signed)
        begin
            if (mag[VALUE_W-1])
            begin
                mag = -mag;
                head.push_back(CH_MINUS);
            end
            else if (f.plus_sign)
                head.push_back(CH_PLUS);
            else if (f.space_sign)
                head.push_back(CH_SPACE);
        end
        if (f.alt_prefix && radix != 10)
        begin
            head.push_back(CH_ZERO);
            if (radix == 16)
                head.push_back(CH_X);
        end

        // always at least one digit, even for zero
        do
        begin
            d = mag % radix;
            digits.push_front((d < 10) ? CH_ZERO + d[7:0] : CH_A + d[7:0] - 8'd10);
            mag = mag / radix;
        end while (mag != 0);

        zeros = (prec > digits.size()) ? prec - digits.size() : 0;
        body  = head.size() + zeros + digits.size();
        pad   = (fw > body) ? fw - body : 0;

        if (!f.left_justify && !f.zero_pad)
            repeat (pad) put_char(txt, CH_SPACE);
        foreach (head[i]) put_char(txt, head[i]);
        if (!f.left_justify && f.zero_pad)
            repeat (pad) put_char(txt, CH_ZERO);
        repeat (zeros) put_char(txt, CH_ZERO);
        foreach (digits[i]) put_char(txt, digits[i]);
        if (f.left_justify)
            repeat (pad) put_char(txt, CH_SPACE);
    endfunction

    function automatic void add_row(input logic [VALUE_W-1:0] v, input logic sgn,
                                    input logic [1:0] base, input logic [4:0] flags,
                                    input int fw, input int prec, input string text);
        dir_row_t r;
        r.fmt.value        = v;
        r.fmt.is_signed    = sgn;
        r.fmt.base_sel     = base;
        {r.fmt.left_justify, r.fmt.plus_sign, r.fmt.space_sign,
         r.fmt.alt_prefix, r.fmt.zero_pad} = flags;
        r.fmt.min_width    = fw[FW_W-1:0];
        r.fmt.precision    = prec[PREC_W-1:0];
        r.text             = text;
        dir_rows.push_back(r);
    endfunction

    // wait length in cycles; calm stretches of several items draw no waits
    function automatic int draw_wait(ref int run_left, ref bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(5, 20);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic num_fmt_t random_number();
        num_fmt_t f;
        case ($urandom_range(0, 5))
            0: f.value = 64'($urandom_range(0, 20));
            1: f.value = -64'($urandom_range(1, 1000));
            2: f.value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            3: f.value = ($urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                                : 64'hFFFF_FFFF_FFFF_FFFF)
                         ^ 64'($urandom_range(0, 3));
            default: f.value = {$urandom, $urandom};
        endcase
        f.is_signed    = 1'($urandom_range(0, 1));
        f.base_sel     = ($urandom_range(0, 7) == 0) ? BASE_HEX_ALT
                                                     : 2'($urandom_range(0, 2));
        f.left_justify = 1'($urandom_range(0, 1));
        f.plus_sign    = 1'($urandom_range(0, 1));
        f.space_sign   = 1'($urandom_range(0, 1));
        f.alt_prefix   = 1'($urandom_range(0, 1));
        f.zero_pad     = 1'($urandom_range(0, 1));
        // mostly short fields; now and then anything up to the port limit
        f.min_width    = ($urandom_range(0, 3) == 0) ? FW_W'($urandom_range(0, 127))
                                                     : FW_W'($urandom_range(0, 24));
        f.precision    = ($urandom_range(0, 3) == 0) ? PREC_W'($urandom_range(0, 63))
                                                     : PREC_W'($urandom_range(0, 24));
        return f;
    endfunction

    int  send_run  = 0;
    bit  send_calm = 1'b0;

    // drive one number and queue its text once the block takes it
    task automatic send_number(input num_fmt_t f, input string text);
        int                gap;
        logic [CHAR_W-1:0] txt[$];
        text_char_t        tc;

        gap = draw_wait(send_run, send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_number(f);
        do
            @(posedge clk);
        while (!s_tready);

        if (text.len() > 0)
        begin
            for (int i = 0; i < text.len(); i++)
                txt.push_back(text[i]);
        end
        else
            format_number(f, txt);
        foreach (txt[i])
        begin
            tc.ch   = txt[i];
            tc.last = (i == txt.size() - 1);
            pending_chars.push_back(tc);
        end
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        // directed table
        add_row(64'd0,    1'b0, BASE_DEC, F_NONE,          0, 0, "0");
        add_row(64'd0,    1'b0, BASE_OCT, F_ALT,           0, 0, "00");
        add_row(64'd0,    1'b0, BASE_HEX, F_ALT,           0, 0, "0x0");
        add_row(64'd0,    1'b0, BASE_HEX, F_NONE,          0, 0, "0");
        add_row(64'hFF,   1'b0, BASE_HEX, F_NONE,          0, 0, "FF");
        add_row(64'hAB,   1'b0, BASE_HEX_ALT, F_NONE,      0, 0, "AB");
        add_row('1,       1'b0, BASE_DEC, F_NONE,          0, 0, "18446744073709551615");
        add_row('1,       1'b1, BASE_DEC, F_NONE,          0, 0, "-1");
        add_row('1,       1'b1, BASE_HEX, F_ALT,           0, 0, "-0x1");
        add_row(64'h8000_0000_0000_0000, 1'b1, BASE_DEC, F_NONE, 0, 0,
                "-9223372036854775808");
        add_row(64'h8000_0000_0000_0000, 1'b0, BASE_OCT, F_ALT, 0, 0, "");
        add_row(64'd42,   1'b1, BASE_DEC, F_PLUS,          0, 0, "+42");
        add_row(64'd42,   1'b1, BASE_DEC, F_SPACE,         0, 0, " 42");
        add_row(64'd42,   1'b1, BASE_DEC, F_PLUS | F_SPACE, 0, 0, "+42");
        add_row(64'd42,   1'b0, BASE_DEC, F_PLUS | F_SPACE, 0, 0, "42");
        add_row(-64'd5,   1'b1, BASE_DEC, F_ZPAD,          6, 0, "-00005");
        add_row(-64'd5,   1'b1, BASE_DEC, F_LEFT | F_ZPAD, 6, 0, "-5    ");
        add_row(-64'd5,   1'b1, BASE_DEC, F_NONE,          6, 0, "    -5");
        add_row(64'h1F,   1'b0, BASE_HEX, F_ALT | F_ZPAD,  10, 0, "0x0000001F");
        add_row(64'd7,    1'b0, BASE_DEC, F_NONE,          0, 5, "00007");
        add_row(64'd12345, 1'b0, BASE_DEC, F_NONE,         3, 0, "12345");
        // saturated width and precision, longest texts
        add_row(64'd5,    1'b0, BASE_DEC, F_ZPAD,          127, 0, "");
        add_row(64'd7,    1'b0, BASE_OCT, F_NONE,          0, 63, "");
        add_row('1,       1'b0, BASE_OCT, F_ALT,           127, 48, "");
        add_row(-64'd1234, 1'b1, BASE_DEC, F_LEFT | F_PLUS, 64, 48, "");

        repeat (RESET_CYC) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_number(dir_rows[i].fmt, dir_rows[i].text);
        repeat (RANDOM_NUMS)
            send_number(random_number(), "");
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        // stray characters after the last one would show up here
        repeat (TAIL_CYC) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver: random back-pressure between characters
    initial
    begin
        int  stall;
        int  recv_run;
        bit  recv_calm;

        recv_run  = 0;
        recv_calm = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(recv_run, recv_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // output check against the oldest queued character
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("text_char 0x%02h with nothing expected", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch)
                begin
                    $error("text_char: expected 0x%02h, got 0x%02h", want.ch, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_char: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
